FILE: hw/rtl/url_percent_decoder_defines.svh
// Assertion macros for the URL percent decoder.
// Included by the top level; no other dependencies.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define UPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upd check failed: same-cycle implication");
`define UPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upd check failed: next-cycle implication");
`else
`define UPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/upd_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies.
package upd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } enc_item_t;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       run_end;
        logic       string_end;
    } dec_item_t;

    localparam int unsigned MAX_RUN = 3;

    // Up to three decoded bytes produced by one request.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [1:0]              count;
        logic                    last;
    } run_t;

    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT   = 8'h25;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

    // Held-byte counts.
    localparam logic [1:0] HELD_NONE    = 2'd0;
    localparam logic [1:0] HELD_PCT     = 2'd1;
    localparam logic [1:0] HELD_PCT_HEX = 2'd2;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
                 ((c >= 8'h61) && (c <= 8'h66)) ||
                 ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Letters a-f / A-F have low nibble 1..6.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= 8'h39)
        begin
            hex_nibble = c[3:0];
        end
        else
        begin
            hex_nibble = 4'(c[3:0] - 4'd1 + HEX_ALPHA_BASE);
        end
    endfunction

endpackage

FILE: hw/rtl/url_percent_decoder.sv
`timescale 1ns / 1ps
// URL percent decoder (form-urlencoded). One raw byte is taken per request on the
// enc channel; decoded bytes leave on the dec channel one per cycle while dec_ready
// is high, with run_end on the last byte a request causes and string_end on the
// last byte of a string. Requests are taken one per cycle while the run queue has
// room; a request yielding several bytes holds the output port until all are sent,
// since the back end sends one byte per cycle. With the queue empty, a request's
// first byte is visible the cycle after it is taken. A QUEUE_DEPTH-entry run queue
// between front and back lets input continue while output is stalled, until full.
module url_percent_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enc_valid,
    output logic               enc_ready,
    input  upd_pkg::enc_item_t enc_item,
    output logic               dec_valid,
    input  logic               dec_ready,
    output upd_pkg::dec_item_t dec_item
);
    import upd_pkg::*;

    `include "url_percent_decoder_defines.svh"

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    run_t q_in;
    run_t q_head;
    logic eos_take;
    logic dec_str_end;

    assign eos_take    = enc_valid && enc_ready && enc_item.end_of_string;
    assign dec_str_end = dec_valid && dec_item.string_end;

    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc_item  (enc_item),
        .q_full    (q_full),
        .run_push  (q_push),
        .run       (q_in)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_run   (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_valid),
        .pop        (q_pop),
        .dec_valid  (dec_valid),
        .dec_ready  (dec_ready),
        .dec_item   (dec_item)
    );

    `UPD_ASSERT_IMP(a_no_overflow, clk, rst_n, q_push, !q_full)
    `UPD_ASSERT_IMP(a_eos_yields_run, clk, rst_n, eos_take, q_push)
    `UPD_ASSERT_IMP(a_str_end_ends_run, clk, rst_n, dec_str_end, dec_item.run_end)
    `UPD_ASSERT_NXT(a_push_shows_out, clk, rst_n, q_push, dec_valid)

endmodule

FILE: hw/rtl/upd_front.sv
`timescale 1ns / 1ps
// Front end: takes raw bytes, tracks held percent/hex bytes, and builds runs.
// Depends on upd_pkg.
module upd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enc_valid,
    output logic              enc_ready,
    input  upd_pkg::enc_item_t enc_item,
    input  logic              q_full,
    output logic              run_push,
    output upd_pkg::run_t     run
);
    import upd_pkg::*;

    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [7:0] held_hex_reg;
    logic [7:0] held_hex_next;
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [1:0] n;
    logic       do_fresh;
    logic [7:0] b;
    logic       accept;

    assign enc_ready = !q_full;
    assign accept    = enc_valid && enc_ready;
    assign b         = enc_item.data_byte;

    always_comb
    begin
        n               = 2'd0;
        bytes           = '0;
        held_count_next = held_count_reg;
        held_hex_next   = held_hex_reg;
        do_fresh        = 1'b0;

        case (held_count_reg)
            HELD_NONE:
            begin
                do_fresh = 1'b1;
            end
            HELD_PCT:
            begin
                if (is_hex(b))
                begin
                    held_count_next = HELD_PCT_HEX;
                    held_hex_next   = b;
                end
                else
                begin
                    bytes[n]        = CHAR_PERCENT;
                    n               = n + 2'd1;
                    held_count_next = HELD_NONE;
                    do_fresh        = 1'b1;
                end
            end
            default:
            begin
                // two held bytes (an impossible count of three lands here too)
                held_count_next = HELD_NONE;
                if (is_hex(b))
                begin
                    bytes[n] = {hex_nibble(held_hex_reg), hex_nibble(b)};
                    n        = n + 2'd1;
                end
                else
                begin
                    bytes[n] = CHAR_PERCENT;
                    n        = n + 2'd1;
                    bytes[n] = held_hex_reg;
                    n        = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
        endcase

        if (do_fresh)
        begin
            if (b == CHAR_PLUS)
            begin
                bytes[n] = CHAR_SPACE;
                n        = n + 2'd1;
            end
            else if (b == CHAR_PERCENT)
            begin
                held_count_next = HELD_PCT;
            end
            else
            begin
                bytes[n] = b;
                n        = n + 2'd1;
            end
        end

        // end of string: flush whatever is still held, in order
        if (enc_item.end_of_string)
        begin
            if (held_count_next != HELD_NONE)
            begin
                bytes[n] = CHAR_PERCENT;
                n        = n + 2'd1;
            end
            if (held_count_next == HELD_PCT_HEX)
            begin
                bytes[n] = held_hex_next;
                n        = n + 2'd1;
            end
            held_count_next = HELD_NONE;
        end
    end

    assign run_push  = accept && (n != 2'd0);
    assign run.bytes = bytes;
    assign run.count = n;
    assign run.last  = enc_item.end_of_string;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= HELD_NONE;
            held_hex_reg   <= 8'h00;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            held_hex_reg   <= held_hex_next;
        end
    end

endmodule

FILE: hw/rtl/upd_queue.sv
`timescale 1ns / 1ps
// Small FIFO of decoded runs between the front and back ends.
// Depends on upd_pkg.
module upd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  upd_pkg::run_t push_run,
    output logic          full,
    input  logic          pop,
    output upd_pkg::run_t head,
    output logic          head_valid
);
    import upd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

FILE: hw/rtl/upd_back.sv
`timescale 1ns / 1ps
// Back end: walks the head run one byte per cycle, while dec_ready is high, onto the output channel.
// Depends on upd_pkg.
module upd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  upd_pkg::run_t      head,
    input  logic               head_valid,
    output logic               pop,
    output logic               dec_valid,
    input  logic               dec_ready,
    output upd_pkg::dec_item_t dec_item
);
    import upd_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       run_last;
    logic       take;

    assign dec_valid = head_valid;
    assign run_last  = (idx_reg == 2'(head.count - 2'd1));
    assign take      = dec_valid && dec_ready;
    assign pop       = take && run_last;

    assign dec_item.decoded_byte = head.bytes[idx_reg];
    assign dec_item.run_end      = run_last;
    assign dec_item.string_end   = run_last && head.last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
